[design/owl_pkg.sv]
// Shared types and constants for the ordered waiting list table.
`timescale 1ns / 1ps

package owl_pkg;

  localparam int unsigned ID_PORT_W = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned HELD_W    = 11;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_FIRST  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ADDED,
    RES_FULL,
    RES_MISS,
    RES_FOUND,
    RES_REMOVED
  } res_op_e;

  typedef struct packed {
    logic    cap;
    logic    scan_start;
    logic    scan_step;
    logic    add_wr;
    logic    shift_wr;
    logic    dec_count;
    res_op_e res_op;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic shift_ok;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

[design/owl_ctrl.sv]
// Request sequencer for the ordered waiting list table.
`timescale 1ns / 1ps

module owl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  owl_pkg::sts_t sts_i,
  output owl_pkg::cmd_t cmd_o
);

  owl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= owl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res_op = owl_pkg::RES_NONE;
    unique case (state_q)
      owl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = owl_pkg::S_DISPATCH;
        end
      end
      owl_pkg::S_DISPATCH: begin
        unique case (sts_i.req_type) inside
          owl_pkg::REQ_ADD: begin
            if (sts_i.full) begin
              cmd_o.res_op = owl_pkg::RES_FULL;
            end else begin
              cmd_o.add_wr = 1'b1;
              cmd_o.res_op = owl_pkg::RES_ADDED;
            end
            state_d = owl_pkg::S_RESP;
          end
          owl_pkg::REQ_REMOVE, owl_pkg::REQ_FIND, owl_pkg::REQ_FIRST: begin
            if (sts_i.empty) begin
              cmd_o.res_op = owl_pkg::RES_MISS;
              state_d      = owl_pkg::S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = owl_pkg::S_SCAN;
            end
          end
          default: state_d = owl_pkg::S_RESP;
        endcase
      end
      owl_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          if (sts_i.req_type == owl_pkg::REQ_REMOVE) begin
            cmd_o.res_op = owl_pkg::RES_REMOVED;
            state_d      = owl_pkg::S_SHIFT;
          end else begin
            cmd_o.res_op = owl_pkg::RES_FOUND;
            state_d      = owl_pkg::S_RESP;
          end
        end else if (sts_i.last) begin
          cmd_o.res_op = owl_pkg::RES_MISS;
          state_d      = owl_pkg::S_RESP;
        end
      end
      owl_pkg::S_SHIFT: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.shift_wr  = sts_i.shift_ok;
        if (sts_i.shift_done) begin
          cmd_o.dec_count = 1'b1;
          state_d         = owl_pkg::S_RESP;
        end
      end
      owl_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = owl_pkg::S_IDLE;
        end
      end
      default: state_d = owl_pkg::S_IDLE;
    endcase
  end

endmodule

[design/owl_dp.sv]
// Entry memory, scan pointers, result and output registers.
`timescale 1ns / 1ps

module owl_dp #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  owl_pkg::cmd_t cmd_i,
  output owl_pkg::sts_t sts_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   requester_id_i,
  input  logic [31:0]   item_id_i,
  input  logic [31:0]   request_time_i,
  input  logic          priority_flag_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [9:0]    match_position_o,
  output logic [31:0]   match_requester_o,
  output logic [31:0]   match_item_o,
  output logic [31:0]   match_time_o,
  output logic          match_priority_o,
  output logic [10:0]   entries_held_o
);

  localparam int unsigned IdPortW = owl_pkg::ID_PORT_W;
  localparam int unsigned TimeW   = owl_pkg::TIME_W;
  localparam int unsigned PosW    = owl_pkg::POS_W;
  localparam int unsigned HeldW   = owl_pkg::HELD_W;
  localparam int unsigned KeyW    = (ID_WIDTH < IdPortW) ? ID_WIDTH : IdPortW;
  localparam int unsigned EntW    = 2 * KeyW + TimeW + 1;
  localparam int unsigned AddrW   = $clog2(CAPACITY);
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntCap = CntW'(CAPACITY);

  // entry layout: {priority, time, item, requester}
  localparam int unsigned ItemLo = KeyW;
  localparam int unsigned TimeLo = 2 * KeyW;
  localparam int unsigned PrioB  = 2 * KeyW + TimeW;

  owl_pkg::req_e       req_type_q;
  logic [KeyW-1:0]     req_key_q;
  logic [KeyW-1:0]     item_key_q;
  logic [TimeW-1:0]    time_q;
  logic                prio_q;

  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     ptr_q;
  logic [CntW-1:0]     chk_q;
  logic                vld_q;

  logic [EntW-1:0]     mem_q [CAPACITY];
  logic [EntW-1:0]     rdata_q;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [EntW-1:0]     wdata;
  logic [CntW-1:0]     chk_prev;

  owl_pkg::status_e    res_status_q;
  logic [CntW-1:0]     res_pos_q;
  logic [EntW-1:0]     res_entry_q;

  logic                out_valid_q;
  owl_pkg::status_e    out_status_q;
  logic [CntW-1:0]     out_pos_q;
  logic [EntW-1:0]     out_entry_q;
  logic [CntW-1:0]     out_held_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_type_q <= owl_pkg::req_e'(req_type_i);
      req_key_q  <= KeyW'(requester_id_i);
      item_key_q <= KeyW'(item_id_i);
      time_q     <= request_time_i;
      prio_q     <= priority_flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (cmd_i.add_wr) begin
        count_q <= count_q + CntOne;
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CntOne;
      end
      if (cmd_i.scan_start) begin
        vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_step) begin
      ptr_q <= ptr_q + CntOne;
      chk_q <= ptr_q;
    end
  end

  assign chk_prev = chk_q - CntOne;

  always_comb begin
    we    = cmd_i.add_wr | cmd_i.shift_wr;
    waddr = cmd_i.add_wr ? count_q[AddrW-1:0] : chk_prev[AddrW-1:0];
    wdata = cmd_i.add_wr ? {prio_q, time_q, item_key_q, req_key_q} : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[ptr_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      owl_pkg::RES_ADDED: begin
        res_status_q <= owl_pkg::ST_OK;
        res_pos_q    <= count_q;
        res_entry_q  <= '0;
      end
      owl_pkg::RES_FULL: begin
        res_status_q <= owl_pkg::ST_FULL;
        res_pos_q    <= '0;
        res_entry_q  <= '0;
      end
      owl_pkg::RES_MISS: begin
        res_status_q <= owl_pkg::ST_MISS;
        res_pos_q    <= '0;
        res_entry_q  <= '0;
      end
      owl_pkg::RES_FOUND: begin
        res_status_q <= owl_pkg::ST_OK;
        res_pos_q    <= chk_q;
        res_entry_q  <= rdata_q;
      end
      owl_pkg::RES_REMOVED: begin
        res_status_q <= owl_pkg::ST_OK;
        res_pos_q    <= chk_q;
        res_entry_q  <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_entry_q  <= res_entry_q;
      out_held_q   <= count_q;
    end
  end

  always_comb begin
    sts_o.req_type   = req_type_q;
    sts_o.full       = (count_q >= CntCap);
    sts_o.empty      = (count_q == '0);
    sts_o.hit        = vld_q && (rdata_q[ItemLo +: KeyW] == item_key_q) &&
                       ((req_type_q == owl_pkg::REQ_FIRST) ||
                        (rdata_q[KeyW-1:0] == req_key_q));
    sts_o.last       = vld_q && (chk_q == count_q - CntOne);
    sts_o.shift_ok   = vld_q && (chk_q < count_q);
    sts_o.shift_done = vld_q && (chk_q >= count_q - CntOne);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign match_position_o  = PosW'(out_pos_q);
  assign match_requester_o = IdPortW'(out_entry_q[KeyW-1:0]);
  assign match_item_o      = IdPortW'(out_entry_q[ItemLo +: KeyW]);
  assign match_time_o      = out_entry_q[TimeLo +: TimeW];
  assign match_priority_o  = out_entry_q[PrioB];
  assign entries_held_o    = HeldW'(out_held_q);

endmodule

[design/ordered_waiting_list_table_unit.sv]
// Top level of the ordered waiting list table: sequencer plus datapath.
`timescale 1ns / 1ps

// One request is handled at a time and each produces one result transaction.
// Entries live in a single-port-write, single-read memory of CAPACITY words;
// a lookup reads one entry per cycle, and a remove then moves each later
// entry down one place per cycle. Add, and any request on an empty list,
// goes from dispatch straight to the result step with no scan. A scan stops
// at a hit and reads all held entries on a miss. A new request is taken as
// soon as the previous result sits in the output register; a result still
// waiting there holds the next request in its final step. No clearing pass:
// only entries below the count are ever read.

module ordered_waiting_list_table_unit #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] requester_id_i,
  input  logic [31:0] item_id_i,
  input  logic [31:0] request_time_i,
  input  logic        priority_flag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  match_position_o,
  output logic [31:0] match_requester_o,
  output logic [31:0] match_item_o,
  output logic [31:0] match_time_o,
  output logic        match_priority_o,
  output logic [10:0] entries_held_o
);

  owl_pkg::cmd_t cmd;
  owl_pkg::sts_t sts;

  owl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  owl_dp #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .requester_id_i    (requester_id_i),
    .item_id_i         (item_id_i),
    .request_time_i    (request_time_i),
    .priority_flag_i   (priority_flag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .match_position_o  (match_position_o),
    .match_requester_o (match_requester_o),
    .match_item_o      (match_item_o),
    .match_time_o      (match_time_o),
    .match_priority_o  (match_priority_o),
    .entries_held_o    (entries_held_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dec_count |-> !sts.empty)
    else $error("entry count underflow");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != owl_pkg::ST_OK)) |->
      (match_position_o == '0 && match_requester_o == '0 &&
       match_item_o == '0 && match_time_o == '0 && !match_priority_o))
    else $error("failed request reports nonzero match fields");

endmodule

[verif/tb_ordered_waiting_list_table_unit.sv]
// Self-checking testbench for the ordered waiting list table: directed table and random mix.
`timescale 1ns / 1ps

module tb_ordered_waiting_list_table_unit;

  localparam int TABLE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 258;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    owl_pkg::req_e kind;
    logic [31:0]   rq;
    logic [31:0]   it;
    logic [31:0]   tm;
    logic          pr;
  } owl_request_t;

  typedef struct packed {
    owl_pkg::status_e status;
    logic [9:0]       position;
    logic [31:0]      requester;
    logic [31:0]      item;
    logic [31:0]      stamp;
    logic             prio;
    logic [10:0]      held;
  } owl_result_t;

  typedef struct packed {
    owl_request_t req;
    logic         typed;
    owl_result_t  res;
  } stim_row_t;

  localparam logic [31:0] ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] PAT_A = 32'hA5A5_A5A5;
  localparam logic [31:0] PAT_B = 32'h5A5A_5A5A;

  // Directed rows; typed rows carry their own expected response, the rest use the predictor.
  stim_row_t dir_tab [24] = '{
    '{'{owl_pkg::REQ_FIND, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0}},
    '{'{owl_pkg::REQ_FIRST, ONES, ONES, ONES, 1'b1}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0}},
    '{'{owl_pkg::REQ_REMOVE, 32'h0, 32'h0, ONES, 1'b1}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0}},
    '{'{owl_pkg::REQ_ADD, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_OK, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd1}},
    '{'{owl_pkg::REQ_ADD, ONES, ONES, ONES, 1'b1}, 1'b1,
      '{owl_pkg::ST_OK, 10'd1, 32'h0, 32'h0, 32'h0, 1'b0, 11'd2}},
    '{'{owl_pkg::REQ_FIND, ONES, ONES, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_OK, 10'd1, ONES, ONES, ONES, 1'b1, 11'd2}},
    '{'{owl_pkg::REQ_FIND, 32'h0, 32'h0, ONES, 1'b1}, 1'b1,
      '{owl_pkg::ST_OK, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd2}},
    '{'{owl_pkg::REQ_ADD, PAT_A, PAT_B, 32'h1234_5678, 1'b1}, 1'b1,
      '{owl_pkg::ST_OK, 10'd2, 32'h0, 32'h0, 32'h0, 1'b0, 11'd3}},
    '{'{owl_pkg::REQ_ADD, PAT_B, PAT_B, 32'h8765_4321, 1'b0}, 1'b1,
      '{owl_pkg::ST_OK, 10'd3, 32'h0, 32'h0, 32'h0, 1'b0, 11'd4}},
    '{'{owl_pkg::REQ_FIRST, 32'h0, PAT_B, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_FIND, PAT_B, PAT_B, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_FIND, PAT_A, ONES, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd4}},
    '{'{owl_pkg::REQ_FIND, 32'h0, ONES, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd4}},
    '{'{owl_pkg::REQ_ADD, 32'h0, 32'h0, 32'h1, 1'b1}, 1'b1,
      '{owl_pkg::ST_OK, 10'd4, 32'h0, 32'h0, 32'h0, 1'b0, 11'd5}},
    '{'{owl_pkg::REQ_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_FIND, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_REMOVE, ONES, 32'h0, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd4}},
    '{'{owl_pkg::REQ_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_FIRST, ONES, 32'h0, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd3}},
    '{'{owl_pkg::REQ_REMOVE, ONES, ONES, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_REMOVE, PAT_A, PAT_B, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_REMOVE, PAT_B, PAT_B, 32'h0, 1'b0}, 1'b0, '0},
    '{'{owl_pkg::REQ_FIRST, 32'h0, PAT_B, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_MISS, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0}},
    '{'{owl_pkg::REQ_ADD, ONES, 32'h0, 32'h0, 1'b0}, 1'b1,
      '{owl_pkg::ST_OK, 10'd0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd1}}
  };

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = owl_pkg::REQ_ADD;
  logic [31:0] requester_id_i = '0;
  logic [31:0] item_id_i = '0;
  logic [31:0] request_time_i = '0;
  logic        priority_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  match_position_o;
  logic [31:0] match_requester_o;
  logic [31:0] match_item_o;
  logic [31:0] match_time_o;
  logic        match_priority_o;
  logic [10:0] entries_held_o;

  logic [31:0] requester_mem [TABLE_DEPTH];
  logic [31:0] item_mem [TABLE_DEPTH];
  logic [31:0] stamp_mem [TABLE_DEPTH];
  logic        prio_mem [TABLE_DEPTH];
  int          list_len = 0;
  int          peak_len = 0;

  logic [31:0] requester_pool [6];
  logic [31:0] item_pool [4];

  owl_result_t pending_responses [$];
  int          requests_sent = 0;
  int          responses_seen = 0;
  int          mismatch_count = 0;
  int          full_seen = 0;
  int          miss_seen = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;

  ordered_waiting_list_table_unit #(
    .CAPACITY(TABLE_DEPTH),
    .ID_WIDTH(32)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .requester_id_i   (requester_id_i),
    .item_id_i        (item_id_i),
    .request_time_i   (request_time_i),
    .priority_flag_i  (priority_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .match_position_o (match_position_o),
    .match_requester_o(match_requester_o),
    .match_item_o     (match_item_o),
    .match_time_o     (match_time_o),
    .match_priority_o (match_priority_o),
    .entries_held_o   (entries_held_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one request to the expected table contents and returns its response.
  function automatic owl_result_t predict_table_response(owl_request_t r);
    owl_result_t res;
    int hit;
    res = '0;
    res.status = owl_pkg::ST_OK;
    hit = -1;
    if (r.kind != owl_pkg::REQ_ADD) begin
      for (int i = 0; i < list_len && hit < 0; i++) begin
        if (item_mem[i] == r.it && (r.kind == owl_pkg::REQ_FIRST || requester_mem[i] == r.rq))
          hit = i;
      end
    end
    case (r.kind)
      owl_pkg::REQ_ADD: begin
        if (list_len >= TABLE_DEPTH) begin
          res.status = owl_pkg::ST_FULL;
          full_seen++;
        end else begin
          requester_mem[list_len] = r.rq;
          item_mem[list_len] = r.it;
          stamp_mem[list_len] = r.tm;
          prio_mem[list_len] = r.pr;
          res.position = 10'(list_len);
          list_len++;
        end
      end
      owl_pkg::REQ_REMOVE: begin
        if (hit < 0) begin
          res.status = owl_pkg::ST_MISS;
          miss_seen++;
        end else begin
          for (int j = hit; j < list_len - 1; j++) begin
            requester_mem[j] = requester_mem[j + 1];
            item_mem[j] = item_mem[j + 1];
            stamp_mem[j] = stamp_mem[j + 1];
            prio_mem[j] = prio_mem[j + 1];
          end
          list_len--;
          res.position = 10'(hit);
        end
      end
      default: begin
        if (hit < 0) begin
          res.status = owl_pkg::ST_MISS;
          miss_seen++;
        end else begin
          res.position = 10'(hit);
          res.requester = requester_mem[hit];
          res.item = item_mem[hit];
          res.stamp = stamp_mem[hit];
          res.prio = prio_mem[hit];
        end
      end
    endcase
    res.held = 11'(list_len);
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  function automatic owl_request_t random_request();
    owl_request_t r;
    int roll;
    int pick;
    roll = $urandom_range(0, 99);
    if (roll < 40) r.kind = owl_pkg::REQ_ADD;
    else if (roll < 65) r.kind = owl_pkg::REQ_REMOVE;
    else if (roll < 85) r.kind = owl_pkg::REQ_FIND;
    else r.kind = owl_pkg::REQ_FIRST;
    r.rq = $urandom;
    r.it = $urandom;
    r.tm = $urandom;
    r.pr = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (r.kind != owl_pkg::REQ_ADD && list_len > 0 && roll < 50) begin
      pick = $urandom_range(0, list_len - 1);
      r.rq = requester_mem[pick];
      r.it = item_mem[pick];
    end else if (roll < 85) begin
      r.rq = requester_pool[$urandom_range(0, 5)];
      r.it = item_pool[$urandom_range(0, 3)];
    end
    return r;
  endfunction

  task automatic offer_request(input owl_request_t r, input logic typed,
                               input owl_result_t typed_res);
    int gap;
    owl_result_t model;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= r.kind;
    requester_id_i  <= r.rq;
    item_id_i       <= r.it;
    request_time_i  <= r.tm;
    priority_flag_i <= r.pr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model = predict_table_response(r);
    pending_responses.push_back(typed ? typed_res : model);
    requests_sent++;
  endtask

  task automatic note_failure(input string what, input owl_result_t want,
                              input owl_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, what);
      $display("  exp st=%0d pos=%0d rq=%h it=%h tm=%h pr=%b held=%0d", want.status,
               want.position, want.requester, want.item, want.stamp, want.prio, want.held);
      $display("  got st=%0d pos=%0d rq=%h it=%h tm=%h pr=%b held=%0d", got.status,
               got.position, got.requester, got.item, got.stamp, got.prio, got.held);
    end
  endtask

  always @(posedge clk_i) begin : check_responses
    owl_result_t got;
    owl_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status    = owl_pkg::status_e'(status_o);
      got.position  = match_position_o;
      got.requester = match_requester_o;
      got.item      = match_item_o;
      got.stamp     = match_time_o;
      got.prio      = match_priority_o;
      got.held      = entries_held_o;
      responses_seen++;
      if (pending_responses.size() == 0) begin
        note_failure("response transaction with nothing pending", '0, got);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) note_failure("response mismatch", want, got);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the input backs up.
  initial begin : drive_out_ready
    int stall_left;
    int taken;
    bit pressure_done;
    stall_left = 0;
    taken = 0;
    pressure_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (!pressure_done && taken >= 40) begin
        pressure_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ((out_valid_o && out_ready_i) || $urandom_range(0, 15) == 0)
          stall_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    owl_request_t r;
    owl_result_t none;
    none = '0;
    foreach (requester_pool[i]) requester_pool[i] = $urandom;
    foreach (item_pool[i]) item_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) offer_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 100 && n < 140);
      offer_request(random_request(), 1'b0, none);
    end
    no_idle = 1'b0;

    // Lookups on the newest entry, then removes at both ends of the list.
    if (list_len > 0) begin
      r.kind = owl_pkg::REQ_FIND;
      r.rq = requester_mem[list_len - 1];
      r.it = item_mem[list_len - 1];
      r.tm = '0;
      r.pr = 1'b0;
      offer_request(r, 1'b0, none);
      r.kind = owl_pkg::REQ_FIRST;
      offer_request(r, 1'b0, none);
      r = '{owl_pkg::REQ_REMOVE, requester_mem[0], item_mem[0], 32'h0, 1'b0};
      offer_request(r, 1'b0, none);
    end
    if (list_len > 0) begin
      r.kind = owl_pkg::REQ_REMOVE;
      r.rq = requester_mem[list_len - 1];
      r.it = item_mem[list_len - 1];
      r.tm = '0;
      r.pr = 1'b0;
      offer_request(r, 1'b0, none);
    end
    repeat (3) begin
      r = '{owl_pkg::REQ_ADD, $urandom, $urandom, $urandom, 1'($urandom)};
      offer_request(r, 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d requests (%0d responses checked), peak list length %0d entries,",
             requests_sent, responses_seen, peak_len);
    $display("with %0d full and %0d no-match responses; %0d mismatches in %0d cycles.",
             full_seen, miss_seen, mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[ordered_waiting_list_table_unit.f]
design/owl_pkg.sv
design/owl_ctrl.sv
design/owl_dp.sv
design/ordered_waiting_list_table_unit.sv
verif/tb_ordered_waiting_list_table_unit.sv
